[src/confidence_abstention_gate_macros.svh]
// assertion macros for the abstention gate
`ifndef CONFIDENCE_ABSTENTION_GATE_MACROS_SVH
`define CONFIDENCE_ABSTENTION_GATE_MACROS_SVH

// property checked on every rising edge outside reset
`define CAG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked on every rising edge outside reset
`define CAG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[src/cag_pkg.sv]
// shared types, constants and functions of the abstention gate
package cag_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int NUM_LANES   = 4;
  localparam int Q_W         = 16;

  localparam logic [Q_W-1:0] THR_RESET   = 16'd30474;
  localparam logic [Q_W-1:0] THR_LO      = 16'd16384;
  localparam logic [Q_W-1:0] THR_HI      = 16'd32768;
  localparam logic [Q_W-1:0] AGREE_LEVEL = 16'd22938;
  localparam logic [Q_W-1:0] GAP_MAX     = 16'd3277;
  localparam logic [Q_W-1:0] VAR_MAX     = 16'd4915;
  localparam logic [Q_W-1:0] RISK_HALF   = 16'd16384;
  localparam logic [Q_W-1:0] RATE_FULL   = 16'd32768;
  localparam logic [2:0]     AGREE_MIN   = 3'd3;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 248;

  typedef enum logic [2:0] {
    WHY_NONE     = 3'd0,
    WHY_LOW_CONF = 3'd1,
    WHY_DISAGREE = 3'd2,
    WHY_GAP      = 3'd3,
    WHY_UNSTABLE = 3'd4
  } why_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MERGE,
    S_SQUARE,
    S_DECIDE,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic            agree;
    logic [Q_W-1:0]  x;
    logic [2*Q_W-1:0] sq;
  } lane_res_t;

  typedef struct packed {
    logic st1;
    logic st2;
  } merge_ctl_t;

  function automatic logic [Q_W-1:0] risk_table(input logic [Q_W-1:0] c);
    logic [Q_W-1:0] r;
    if (c >= 16'd30474)      r = 16'd131;
    else if (c >= 16'd28508) r = 16'd2392;
    else if (c >= 16'd26214) r = 16'd4981;
    else if (c >= 16'd23921) r = 16'd3277;
    else                     r = 16'd6554;
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic [COUNT_WIDTH-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
    return (&c) ? c : c + COUNT_WIDTH'(1);
  endfunction

endpackage

[src/confidence_abstention_gate.sv]
// top level of the confidence abstention gate
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata 96b, tuser req_type
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata 248b result
//  cfg       in   cfg_valid/cfg_ready            cfg_data threshold
//
// an evaluate request passes from accept to result through the merge, square and
// decision states, the serial rate divider (start, 15 quotient bits, done) and the
// output load; a request whose rate is zero or full skips the quotient bits
// the next request can be accepted in the cycle after the result is loaded
// rst clears counters and control and reloads the threshold; the result register
// holds under a stalled m_axis_tready and the next request is taken while it waits
module confidence_abstention_gate (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // overall_conf, signal_conf, response_conf, topology_conf, graph_conf, calib_gap
  input  logic [95:0]  s_axis_tdata,
  // req_type
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // abstain, why, fp_risk, agree_count, feature_variance, predictions_seen,
  // abstentions_seen, low_conf_seen, disagree_seen, gap_seen, unstable_seen,
  // abstain_rate, zero pad
  output logic [247:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [15:0]  cfg_data
);

  `include "confidence_abstention_gate_macros.svh"

  localparam int CW = cag_pkg::COUNT_WIDTH;

  cag_pkg::state_t state, state_next;

  logic [15:0] thr;
  logic        req_clear;
  logic [15:0] conf;
  logic [15:0] gap;

  logic [CW-1:0] pred_cnt, abst_cnt, low_cnt, dis_cnt, gap_cnt, unst_cnt;

  cag_pkg::lane_res_t [cag_pkg::NUM_LANES-1:0] lanes;
  cag_pkg::merge_ctl_t mctl;
  logic [2:0]  agree_cnt;
  logic [15:0] variance;

  logic        accept;
  logic        div_start;
  logic        div_done;
  logic [15:0] div_q;
  logic        out_load;

  logic           abst, abst_next;
  cag_pkg::why_t  why, why_next;
  logic [15:0]    risk, risk_next;
  logic [2:0]     agree_o, agree_o_next;
  logic [15:0]    var_o, var_o_next;

  assign cfg_ready = 1'b1;
  assign accept    = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= cag_pkg::THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_data < cag_pkg::THR_LO)      thr <= cag_pkg::THR_LO;
      else if (cfg_data > cag_pkg::THR_HI) thr <= cag_pkg::THR_HI;
      else                                 thr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_clear <= s_axis_tuser;
      conf      <= s_axis_tdata[15:0];
      gap       <= s_axis_tdata[95:80];
    end
  end

  for (genvar i = 0; i < cag_pkg::NUM_LANES; i++) begin : g_lane
    cag_lane u_lane (
      .clk  (clk),
      .load (accept),
      .x    (s_axis_tdata[16*(i+1) +: 16]),
      .res  (lanes[i])
    );
  end

  cag_merge u_merge (
    .clk       (clk),
    .ctl       (mctl),
    .lanes     (lanes),
    .agree_cnt (agree_cnt),
    .variance  (variance)
  );

  cag_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (abst_cnt),
    .divisor  (pred_cnt),
    .done     (div_done),
    .quot     (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= cag_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    mctl          = '0;
    out_load      = 1'b0;
    unique case (state)
      cag_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_next = cag_pkg::S_MERGE;
      end
      cag_pkg::S_MERGE: begin
        mctl.st1   = 1'b1;
        state_next = cag_pkg::S_SQUARE;
      end
      cag_pkg::S_SQUARE: begin
        mctl.st2   = 1'b1;
        state_next = cag_pkg::S_DECIDE;
      end
      cag_pkg::S_DECIDE: begin
        state_next = cag_pkg::S_DIV;
      end
      cag_pkg::S_DIV: begin
        if (div_done) state_next = cag_pkg::S_OUT;
      end
      cag_pkg::S_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = cag_pkg::S_IDLE;
        end
      end
      default: state_next = cag_pkg::S_IDLE;
    endcase
  end

  // counters settle at the decision edge, the divider starts right after
  logic decided;
  always_ff @(posedge clk) begin
    if (rst) decided <= 1'b0;
    else     decided <= (state == cag_pkg::S_DECIDE);
  end
  assign div_start = decided;

  always_comb begin
    abst_next    = 1'b0;
    why_next     = cag_pkg::WHY_NONE;
    risk_next    = '0;
    agree_o_next = '0;
    var_o_next   = '0;
    if (!req_clear) begin
      if (conf < thr) begin
        abst_next = 1'b1;
        why_next  = cag_pkg::WHY_LOW_CONF;
        risk_next = cag_pkg::risk_table(conf);
      end else begin
        agree_o_next = agree_cnt;
        if (agree_cnt < cag_pkg::AGREE_MIN) begin
          abst_next = 1'b1;
          why_next  = cag_pkg::WHY_DISAGREE;
          risk_next = cag_pkg::RISK_HALF;
        end else if (gap > cag_pkg::GAP_MAX) begin
          abst_next = 1'b1;
          why_next  = cag_pkg::WHY_GAP;
          risk_next = gap;
        end else begin
          var_o_next = variance;
          if (variance > cag_pkg::VAR_MAX) begin
            abst_next = 1'b1;
            why_next  = cag_pkg::WHY_UNSTABLE;
            risk_next = variance;
          end else begin
            risk_next = cag_pkg::risk_table(conf);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == cag_pkg::S_DECIDE) begin
      abst    <= abst_next;
      why     <= why_next;
      risk    <= risk_next;
      agree_o <= agree_o_next;
      var_o   <= var_o_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pred_cnt <= '0;
      abst_cnt <= '0;
      low_cnt  <= '0;
      dis_cnt  <= '0;
      gap_cnt  <= '0;
      unst_cnt <= '0;
    end else if (state == cag_pkg::S_DECIDE) begin
      if (req_clear) begin
        pred_cnt <= '0;
        abst_cnt <= '0;
        low_cnt  <= '0;
        dis_cnt  <= '0;
        gap_cnt  <= '0;
        unst_cnt <= '0;
      end else begin
        pred_cnt <= cag_pkg::bump(pred_cnt);
        if (abst_next) abst_cnt <= cag_pkg::bump(abst_cnt);
        case (why_next)
          cag_pkg::WHY_LOW_CONF: low_cnt  <= cag_pkg::bump(low_cnt);
          cag_pkg::WHY_DISAGREE: dis_cnt  <= cag_pkg::bump(dis_cnt);
          cag_pkg::WHY_GAP:      gap_cnt  <= cag_pkg::bump(gap_cnt);
          cag_pkg::WHY_UNSTABLE: unst_cnt <= cag_pkg::bump(unst_cnt);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {1'b0, div_q,
                       cag_pkg::sat32(unst_cnt), cag_pkg::sat32(gap_cnt),
                       cag_pkg::sat32(dis_cnt), cag_pkg::sat32(low_cnt),
                       cag_pkg::sat32(abst_cnt), cag_pkg::sat32(pred_cnt),
                       var_o, agree_o, risk, why, abst};
    end
  end

  `CAG_ASSERT(a_abst_le_pred, abst_cnt <= pred_cnt, "abstentions exceed predictions")
  `CAG_ASSERT_IMP(a_div_in_div, div_done, state == cag_pkg::S_DIV,
                  "rate divider finished outside its wait state")
  `CAG_ASSERT_IMP(a_why_abst, m_axis_tvalid,
                  (m_axis_tdata[0] == 1'b0) == (m_axis_tdata[3:1] == cag_pkg::WHY_NONE),
                  "abstain flag and reason disagree")
  `CAG_ASSERT(a_thr_range, thr >= cag_pkg::THR_LO && thr <= cag_pkg::THR_HI,
              "threshold out of range")

endmodule

[src/cag_lane.sv]
// one feature lane: agreement flag and square of a feature confidence
module cag_lane (
  input  logic                 clk,
  input  logic                 load,
  input  logic [15:0]          x,
  output cag_pkg::lane_res_t   res
);

  always_ff @(posedge clk) begin
    if (load) begin
      res.x     <= x;
      res.agree <= (x >= cag_pkg::AGREE_LEVEL);
      res.sq    <= 32'(x) * 32'(x);
    end
  end

endmodule

[src/cag_merge.sv]
// merging stage: agreement count, sums and population variance of the lanes
module cag_merge (
  input  logic                                        clk,
  input  cag_pkg::merge_ctl_t                         ctl,
  input  cag_pkg::lane_res_t [cag_pkg::NUM_LANES-1:0] lanes,
  output logic [2:0]                                  agree_cnt,
  output logic [15:0]                                 variance
);

  logic [17:0] sum, sum_next;
  logic [33:0] sqsum, sqsum_next;
  logic [2:0]  cnt_next;
  logic [35:0] sum_sq;
  logic [35:0] sq4;
  logic [35:0] diff;

  always_comb begin
    sum_next   = '0;
    sqsum_next = '0;
    cnt_next   = '0;
    for (int i = 0; i < cag_pkg::NUM_LANES; i++) begin
      sum_next   = sum_next + 18'(lanes[i].x);
      sqsum_next = sqsum_next + 34'(lanes[i].sq);
      cnt_next   = cnt_next + 3'(lanes[i].agree);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.st1) begin
      sum       <= sum_next;
      sqsum     <= sqsum_next;
      agree_cnt <= cnt_next;
    end
    if (ctl.st2) begin
      sum_sq <= 36'(sum) * 36'(sum);
      sq4    <= {sqsum, 2'b00};
    end
  end

  // 4*sum(x^2) - (sum x)^2 over 16*32768
  assign diff     = sq4 - sum_sq;
  assign variance = diff[34:19];

endmodule

[src/cag_div.sv]
// restoring divider for the abstention rate, one quotient bit per cycle
module cag_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [cag_pkg::COUNT_WIDTH-1:0] dividend,
  input  logic [cag_pkg::COUNT_WIDTH-1:0] divisor,
  output logic                            done,
  output logic [15:0]                     quot
);

  localparam int CW = cag_pkg::COUNT_WIDTH;

  logic          busy;
  logic [3:0]    cnt;
  logic [CW-1:0] rem;
  logic [CW-1:0] den;
  logic [CW:0]   rem2;

  assign rem2 = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        den <= divisor;
        rem <= dividend;
        if (divisor == '0) begin
          quot <= '0;
          done <= 1'b1;
        end else if (dividend >= divisor) begin
          quot <= cag_pkg::RATE_FULL;
          done <= 1'b1;
        end else begin
          quot <= '0;
          cnt  <= 4'd15;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (rem2 >= {1'b0, den}) begin
          rem  <= CW'(rem2 - {1'b0, den});
          quot <= {quot[14:0], 1'b1};
        end else begin
          rem  <= rem2[CW-1:0];
          quot <= {quot[14:0], 1'b0};
        end
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
